### hdl/i2cram_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master package
// Item types, configuration bundle and shared codes.
// ----------------------------------------------------------------------------
package i2cram_pkg;

    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_START_RD = 2'd1;
    localparam logic [1:0] KIND_START_WR = 2'd2;

    localparam logic [1:0] CFG_DEVICE_BYTE     = 2'd0;
    localparam logic [1:0] CFG_ACK_POLL_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_ACK_SETUP_TICKS = 2'd2;
    localparam logic [1:0] CFG_STOP_HOLD_TICKS = 2'd3;

    localparam logic [7:0]  RST_DEVICE_BYTE     = 8'h0c;
    localparam logic [9:0]  RST_ACK_POLL_LIMIT  = 10'd100;
    localparam logic [15:0] RST_ACK_SETUP_TICKS = 16'd4000;
    localparam logic [15:0] RST_STOP_HOLD_TICKS = 16'd5000;

    localparam logic [7:0] DIR_READ_BIT = 8'h01;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_error;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  device_byte;
        logic [9:0]  ack_poll_limit;
        logic [15:0] ack_setup_ticks;
        logic [15:0] stop_hold_ticks;
    } t_cfg;

endpackage

### hdl/i2c_register_access_master_top.sv
// ----------------------------------------------------------------------------
// I2C register access master
// Tick-driven I2C master for single-byte register reads and writes.
// ----------------------------------------------------------------------------
// Each input transaction is one microsecond tick or a start request; every
// accepted transaction yields exactly one result carrying the SCL level, SDA
// drive and status. The block takes one transaction per clock cycle while the
// output is not stalled; the transaction is held in the input register and
// passes the sequencer step into the result register. Throughput is set by
// the single sequencer step between those registers. The configuration
// channel is always ready; write it only while no transaction is running.
module i2c_register_access_master_top
    import i2cram_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg      cfg;
    t_out_item step_result;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    i2cram_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    i2cram_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= step_result;
        end
    end

endmodule

### hdl/i2cram_cfg.sv
// ----------------------------------------------------------------------------
// I2C register access master configuration registers
// Write-only register file; the write channel is always ready.
// ----------------------------------------------------------------------------
module i2cram_cfg
    import i2cram_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_byte     <= RST_DEVICE_BYTE;
            r_cfg.ack_poll_limit  <= RST_ACK_POLL_LIMIT;
            r_cfg.ack_setup_ticks <= RST_ACK_SETUP_TICKS;
            r_cfg.stop_hold_ticks <= RST_STOP_HOLD_TICKS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEVICE_BYTE:     r_cfg.device_byte     <= i_cfg_data[7:0];
                CFG_ACK_POLL_LIMIT:  r_cfg.ack_poll_limit  <= i_cfg_data[9:0];
                CFG_ACK_SETUP_TICKS: r_cfg.ack_setup_ticks <= i_cfg_data;
                CFG_STOP_HOLD_TICKS: r_cfg.stop_hold_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

### hdl/i2cram_ctrl.sv
// ----------------------------------------------------------------------------
// I2C register access master sequencer
// Pin sequence state machine; one step per enabled item, result combinational.
// ----------------------------------------------------------------------------
module i2cram_ctrl
    import i2cram_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    localparam logic [4:0] PH_IDLE     = 5'd0;
    localparam logic [4:0] PH_ST_A     = 5'd1;
    localparam logic [4:0] PH_ST_B     = 5'd2;
    localparam logic [4:0] PH_ST_C     = 5'd3;
    localparam logic [4:0] PH_TX_D     = 5'd4;
    localparam logic [4:0] PH_TX_H     = 5'd5;
    localparam logic [4:0] PH_TX_L     = 5'd6;
    localparam logic [4:0] PH_ACK_REL  = 5'd7;
    localparam logic [4:0] PH_ACK_RISE = 5'd8;
    localparam logic [4:0] PH_ACK_POLL = 5'd9;
    localparam logic [4:0] PH_RX_W     = 5'd10;
    localparam logic [4:0] PH_RX_H     = 5'd11;
    localparam logic [4:0] PH_RX_S     = 5'd12;
    localparam logic [4:0] PH_NACK_A   = 5'd13;
    localparam logic [4:0] PH_NACK_B   = 5'd14;
    localparam logic [4:0] PH_SP_A     = 5'd15;
    localparam logic [4:0] PH_SP_B     = 5'd16;
    localparam logic [4:0] PH_SP_C     = 5'd17;

    logic [4:0]  r_phase,      n_phase;
    logic [15:0] r_wait_count, n_wait_count;
    logic [3:0]  r_bit_count,  n_bit_count;
    logic [1:0]  r_byte_index, n_byte_index;
    logic [7:0]  r_shift_byte, n_shift_byte;
    logic        r_is_read,    n_is_read;
    logic [7:0]  r_reg_latch,  n_reg_latch;
    logic [7:0]  r_data_latch, n_data_latch;
    logic        r_error_flag, n_error_flag;
    logic        r_scl,        n_scl;
    logic        r_sda_drv,    n_sda_drv;
    logic        r_sda_lvl,    n_sda_lvl;
    logic        done;
    logic [15:0] wait_inc;
    logic [3:0]  bit_inc;
    logic [7:0]  rx_shift;

    function automatic logic [7:0] next_byte(
        input logic [1:0] bi,
        input logic       rd,
        input logic [7:0] dev,
        input logic [7:0] rg,
        input logic [7:0] dat
    );
        logic [7:0] b;
        case (bi)
            2'd0:    b = dev;
            2'd1:    b = rg;
            2'd2:    b = rd ? (dev | DIR_READ_BIT) : dat;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    assign wait_inc = r_wait_count + 16'd1;
    assign bit_inc  = r_bit_count + 4'd1;
    assign rx_shift = {r_shift_byte[6:0], i_item.sda_in};

    always_comb begin
        n_phase      = r_phase;
        n_wait_count = r_wait_count;
        n_bit_count  = r_bit_count;
        n_byte_index = r_byte_index;
        n_shift_byte = r_shift_byte;
        n_is_read    = r_is_read;
        n_reg_latch  = r_reg_latch;
        n_data_latch = r_data_latch;
        n_error_flag = r_error_flag;
        n_scl        = r_scl;
        n_sda_drv    = r_sda_drv;
        n_sda_lvl    = r_sda_lvl;
        done         = 1'b0;
        if (i_item.kind == KIND_START_RD || i_item.kind == KIND_START_WR) begin
            if (r_phase == PH_IDLE) begin
                n_is_read    = (i_item.kind == KIND_START_RD);
                n_reg_latch  = i_item.reg_addr;
                n_data_latch = (i_item.kind == KIND_START_RD) ? 8'd0 : i_item.write_data;
                n_error_flag = 1'b0;
                n_byte_index = 2'd0;
                n_bit_count  = 4'd0;
                n_shift_byte = 8'd0;
                n_wait_count = 16'd0;
                n_phase      = PH_ST_A;
            end
        end else if (i_item.kind == KIND_TICK && r_phase != PH_IDLE) begin
            if (r_phase == PH_ACK_POLL) begin
                if (!i_item.sda_in) begin
                    n_scl        = 1'b0;
                    n_wait_count = 16'd0;
                    unique case (r_byte_index)
                        2'd0: begin
                            n_byte_index = 2'd1;
                            n_shift_byte = r_reg_latch;
                            n_bit_count  = 4'd0;
                            n_phase      = PH_TX_D;
                        end
                        2'd1: begin
                            n_byte_index = 2'd2;
                            if (r_is_read) begin
                                n_phase = PH_ST_A;
                            end else begin
                                n_shift_byte = r_data_latch;
                                n_bit_count  = 4'd0;
                                n_phase      = PH_TX_D;
                            end
                        end
                        default: begin
                            if (r_is_read) begin
                                n_bit_count  = 4'd0;
                                n_shift_byte = 8'd0;
                                n_phase      = PH_RX_W;
                            end else begin
                                n_phase = PH_SP_A;
                            end
                        end
                    endcase
                end else begin
                    n_wait_count = wait_inc;
                    if (wait_inc >= {6'd0, i_cfg.ack_poll_limit}) begin
                        n_scl        = 1'b0;
                        n_wait_count = 16'd0;
                        n_error_flag = 1'b1;
                        n_phase      = PH_SP_A;
                    end
                end
            end else if (r_wait_count != 16'd0) begin
                n_wait_count = r_wait_count - 16'd1;
            end else begin
                n_wait_count = 16'd0;
                unique case (r_phase)
                    PH_ST_A: begin
                        n_sda_drv = 1'b1; n_sda_lvl = 1'b1; n_scl = 1'b1;
                        n_wait_count = 16'd5; n_phase = PH_ST_B;
                    end
                    PH_ST_B: begin
                        n_sda_drv = 1'b1; n_sda_lvl = 1'b0;
                        n_wait_count = 16'd4; n_phase = PH_ST_C;
                    end
                    PH_ST_C: begin
                        n_scl        = 1'b0;
                        n_shift_byte = next_byte(r_byte_index, r_is_read,
                                                 i_cfg.device_byte, r_reg_latch,
                                                 r_data_latch);
                        n_bit_count  = 4'd0;
                        n_phase      = PH_TX_D;
                    end
                    PH_TX_D: begin
                        n_sda_drv = 1'b1; n_sda_lvl = r_shift_byte[7];
                        n_wait_count = 16'd2; n_phase = PH_TX_H;
                    end
                    PH_TX_H: begin
                        n_scl = 1'b1; n_wait_count = 16'd4; n_phase = PH_TX_L;
                    end
                    PH_TX_L: begin
                        n_scl        = 1'b0;
                        n_wait_count = 16'd5;
                        n_shift_byte = {r_shift_byte[6:0], 1'b0};
                        n_bit_count  = bit_inc;
                        n_phase      = (bit_inc >= 4'd8) ? PH_ACK_REL : PH_TX_D;
                    end
                    PH_ACK_REL: begin
                        n_sda_drv = 1'b0; n_sda_lvl = 1'b1;
                        n_wait_count = i_cfg.ack_setup_ticks; n_phase = PH_ACK_RISE;
                    end
                    PH_ACK_RISE: begin
                        n_scl = 1'b1; n_phase = PH_ACK_POLL;
                    end
                    PH_RX_W: begin
                        n_sda_drv = 1'b0; n_sda_lvl = 1'b1; n_scl = 1'b0;
                        n_wait_count = 16'd5; n_phase = PH_RX_H;
                    end
                    PH_RX_H: begin
                        n_scl = 1'b1; n_wait_count = 16'd4; n_phase = PH_RX_S;
                    end
                    PH_RX_S: begin
                        n_shift_byte = rx_shift;
                        n_scl        = 1'b0;
                        n_bit_count  = bit_inc;
                        if (bit_inc >= 4'd8) begin
                            n_data_latch = rx_shift;
                            n_phase      = PH_NACK_A;
                        end else begin
                            n_phase = PH_RX_W;
                        end
                    end
                    PH_NACK_A: begin
                        n_sda_drv = 1'b1; n_sda_lvl = 1'b1; n_scl = 1'b1;
                        n_wait_count = 16'd4; n_phase = PH_NACK_B;
                    end
                    PH_NACK_B: begin
                        n_scl = 1'b0; n_wait_count = 16'd4; n_phase = PH_SP_A;
                    end
                    PH_SP_A: begin
                        n_sda_drv = 1'b1; n_sda_lvl = 1'b0; n_scl = 1'b1;
                        n_wait_count = 16'd4; n_phase = PH_SP_B;
                    end
                    PH_SP_B: begin
                        n_sda_drv = 1'b1; n_sda_lvl = 1'b1;
                        n_wait_count = i_cfg.stop_hold_ticks; n_phase = PH_SP_C;
                    end
                    PH_SP_C: begin
                        n_phase = PH_IDLE; done = 1'b1;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        o_result.scl_level = n_scl;
        o_result.sda_drive = n_sda_drv;
        o_result.sda_level = !n_sda_drv || n_sda_lvl;
        o_result.busy_res  = (n_phase != PH_IDLE);
        o_result.done_res  = done;
        o_result.read_data = (done && n_is_read && !n_error_flag) ? n_data_latch : 8'd0;
        o_result.ack_error = done && n_error_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_wait_count <= 16'd0;
            r_bit_count  <= 4'd0;
            r_byte_index <= 2'd0;
            r_shift_byte <= 8'd0;
            r_is_read    <= 1'b0;
            r_reg_latch  <= 8'd0;
            r_data_latch <= 8'd0;
            r_error_flag <= 1'b0;
            r_scl        <= 1'b1;
            r_sda_drv    <= 1'b0;
            r_sda_lvl    <= 1'b1;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_wait_count <= n_wait_count;
            r_bit_count  <= n_bit_count;
            r_byte_index <= n_byte_index;
            r_shift_byte <= n_shift_byte;
            r_is_read    <= n_is_read;
            r_reg_latch  <= n_reg_latch;
            r_data_latch <= n_data_latch;
            r_error_flag <= n_error_flag;
            r_scl        <= n_scl;
            r_sda_drv    <= n_sda_drv;
            r_sda_lvl    <= n_sda_lvl;
        end
    end

endmodule

### hdl/i2cram_chk.sv
// ----------------------------------------------------------------------------
// I2C register access master checker
// Port-level assertions, attached to the top level by bind.
// ----------------------------------------------------------------------------
module i2cram_chk
    import i2cram_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_item
);

    a_done_not_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_item.done_res) |-> !i_out_item.busy_res)
        else $error("done shown while busy");

    a_status_only_on_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_item.done_res) |->
            (i_out_item.read_data == 8'd0 && !i_out_item.ack_error))
        else $error("read data or error outside done");

    a_done_after_stop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_item.done_res) |->
            (i_out_item.scl_level && i_out_item.sda_drive && i_out_item.sda_level))
        else $error("done without stop condition on the bus");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_out_item)))
        else $error("stalled result changed");

endmodule

bind i2c_register_access_master_top i2cram_chk u_i2cram_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);
